// ===== rtl/cic_pkg.sv =====
// Shared constants and types for the x16 CIC interpolator.
package cic_pkg;

  localparam int unsigned OrderDefault = 4;
  localparam int unsigned UpFactor     = 16;
  localparam int unsigned CntW         = $clog2(UpFactor);

  localparam int unsigned InW    = 24;  // Q1.23 input sample
  localparam int unsigned QuantW = 17;  // requantized value, can reach +-32768
  localparam int unsigned ErrW   = 9;   // error feedback, -255..255
  localparam int unsigned FracW  = 8;   // bits dropped by the requantizer
  localparam int unsigned AccW   = 32;  // comb and integrator word

  typedef logic signed [InW-1:0]    sample_in_t;
  typedef logic signed [QuantW-1:0] quant_t;
  typedef logic signed [ErrW-1:0]   err_t;
  typedef logic        [AccW-1:0]   acc_t;

endpackage

// ===== rtl/cic_quant.sv =====
// Input register with first-order error-feedback requantizer to 16 bits.
module cic_quant (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cic_pkg::sample_in_t in_sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cic_pkg::quant_t     out_quant_o
);
  import cic_pkg::*;

  localparam int unsigned SumW = InW + 1;

  logic                   valid_q;
  quant_t                 quant_q, quant_d;
  err_t                   err_q, err_d;
  logic signed [SumW-1:0] sum;
  logic                   round_up;
  logic                   accept;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    sum = SumW'(in_sample_i) + SumW'(err_q);
    // truncation toward zero: a negative sum with dropped bits rounds up
    round_up = sum[SumW-1] && (|sum[FracW-1:0]);
    quant_d  = quant_t'(sum[SumW-1:FracW]) + quant_t'(round_up);
    err_d    = {round_up, sum[FracW-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      err_q   <= '0;
    end else begin
      if (accept) begin
        valid_q <= 1'b1;
        err_q   <= err_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      quant_q <= quant_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_quant_o = quant_q;

endmodule

// ===== rtl/cic_comb.sv =====
// Comb section at the input rate; delays advance when a word moves on.
module cic_comb #(
  parameter int unsigned ORDER = cic_pkg::OrderDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cic_pkg::quant_t in_quant_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cic_pkg::acc_t   out_comb_o
);
  import cic_pkg::*;

  acc_t delay_q [ORDER];
  acc_t stage   [ORDER+1];
  logic take;

  assign out_valid_o = in_valid_i;
  assign in_ready_o  = out_ready_i;
  assign take        = in_valid_i && out_ready_i;

  always_comb begin
    stage[0] = AccW'(in_quant_i);
    for (int i = 0; i < ORDER; i++) begin
      stage[i+1] = stage[i] - delay_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ORDER; i++) begin
        delay_q[i] <= '0;
      end
    end else if (take) begin
      for (int i = 0; i < ORDER; i++) begin
        delay_q[i] <= stage[i];
      end
    end
  end

  assign out_comb_o = stage[ORDER];

endmodule

// ===== rtl/cic_integ.sv =====
// Zero-stuffing integrator section and output register, one word per step.
module cic_integ #(
  parameter int unsigned ORDER = cic_pkg::OrderDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cic_pkg::acc_t in_comb_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cic_pkg::acc_t out_sample_o,
  output logic          out_last_o
);
  import cic_pkg::*;

  localparam int unsigned OutShift = 20 - 4 * ORDER;

  logic            active_q;
  logic [CntW-1:0] cnt_q;
  acc_t            comb_q;
  acc_t            sum_q [ORDER];
  acc_t            chain [ORDER+1];
  logic            valid_q;
  acc_t            sample_q;
  logic            last_q;
  logic            step;
  logic            last_step;
  logic            load;

  assign step       = active_q && (!valid_q || out_ready_i);
  assign last_step  = step && (cnt_q == CntW'(UpFactor - 1));
  assign in_ready_o = !active_q || last_step;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    // only the first of the sixteen updates sees the comb output
    chain[0] = (cnt_q == '0) ? comb_q : '0;
    for (int i = 0; i < ORDER; i++) begin
      chain[i+1] = chain[i] + sum_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      valid_q  <= 1'b0;
      for (int i = 0; i < ORDER; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      if (load) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (last_step) begin
        active_q <= 1'b0;
      end else if (step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (step) begin
        valid_q <= 1'b1;
        for (int i = 0; i < ORDER; i++) begin
          sum_q[i] <= chain[i+1];
        end
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      comb_q <= in_comb_i;
    end
    if (step) begin
      sample_q <= chain[ORDER] << OutShift;
      last_q   <= (cnt_q == CntW'(UpFactor - 1));
    end
  end

  assign out_valid_o  = valid_q;
  assign out_sample_o = sample_q;
  assign out_last_o   = last_q;

endmodule

// ===== rtl/cic_interpolator_x16_noise_shaped.sv =====
// x16 CIC interpolator with noise-shaped 16-bit requantizer.
//
// Slave stream: one signed Q1.23 sample per word on s_axis_tdata.
// Master stream: sixteen signed Q1.31 words per input sample on
// m_axis_tdata; m_axis_tlast marks the sixteenth word of each run.
// The input sample is requantized to 16 bits with error feedback and
// registered, then combed (ORDER stages) as it enters the integrator
// section, which emits one word per cycle into the output register.
// An input word reaches the output through the requantizer register,
// the integrator's comb register and the output register. Each run is
// sent at one word per cycle while m_axis_tready is high; the next input
// waits in the requantizer register while the current run is emitted.
// Reset clears the error feedback, comb delays and integrator sums.
// When m_axis_tready is low the integrators stop, the output word holds,
// and once the requantizer register is full s_axis_tready goes low.
module cic_interpolator_x16_noise_shaped #(
  parameter int unsigned ORDER = cic_pkg::OrderDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sample_out
  output logic        m_axis_tlast    // last_of_run
);
  import cic_pkg::*;

  logic   q_valid, q_ready;
  quant_t q_value;
  logic   c_valid, c_ready;
  acc_t   c_value;

  cic_quant u_quant (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (sample_in_t'(s_axis_tdata)),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_quant_o (q_value)
  );

  cic_comb #(
    .ORDER (ORDER)
  ) u_comb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_quant_i  (q_value),
    .out_valid_o (c_valid),
    .out_ready_i (c_ready),
    .out_comb_o  (c_value)
  );

  cic_integ #(
    .ORDER (ORDER)
  ) u_integ (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (c_valid),
    .in_ready_o   (c_ready),
    .in_comb_i    (c_value),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule
